>>> rtl/esuc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode program for the epoch seconds to UTC calendar block.
// No dependencies; used by esuc_core and epoch_seconds_to_utc_calendar.
package esuc_pkg;

    localparam int unsigned ACC_W  = 33;
    localparam int unsigned QUO_W  = 16;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned PC_W   = 4;
    localparam int unsigned DIV_W  = 17;
    localparam int unsigned TDATA_IN_W  = 32;
    localparam int unsigned TDATA_OUT_W = 48;

    // 25202 days from 1901-01-01 to 1970-01-01, in seconds
    localparam logic [ACC_W-1:0] EPOCH_BIAS = 33'd2177452800;
    // 1901-01-01 was a Tuesday
    localparam logic [ACC_W-1:0] WEEK_BIAS  = 33'd2;
    localparam logic [10:0]      DAYS_COMMON_YEAR = 11'd365;
    localparam logic [3:0]       MONTH_DEC = 4'd11;

    typedef enum logic [3:0] {
        OP_IDLE       = 4'd0,
        OP_REDUCE     = 4'd1,
        OP_SPLIT_DAY  = 4'd2,
        OP_PUT_WDAY   = 4'd3,
        OP_PUT_HOUR   = 4'd4,
        OP_PUT_MIN    = 4'd5,
        OP_PUT_CYCLE  = 4'd6,
        OP_YEAR_STEP  = 4'd7,
        OP_PUT_YDAY   = 4'd8,
        OP_MONTH_STEP = 4'd9,
        OP_FINISH     = 4'd10
    } esuc_op_t;

    typedef enum logic [2:0] {
        DIV_DAY   = 3'd0,
        DIV_WEEK  = 3'd1,
        DIV_HOUR  = 3'd2,
        DIV_MIN   = 3'd3,
        DIV_CYCLE = 3'd4
    } esuc_csel_t;

    typedef struct packed {
        esuc_op_t         op;
        esuc_csel_t       csel;
        logic [CNT_W-1:0] cnt;
        logic [PC_W-1:0]  target;
    } esuc_ctl_t;

    typedef struct packed {
        logic start;
        logic take;
    } esuc_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } esuc_stat_t;

    typedef struct packed {
        logic [8:0] day_of_year;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
    } esuc_res_t;

    function automatic logic [DIV_W-1:0] divisor(input esuc_csel_t sel);
        logic [DIV_W-1:0] d;
        case (sel)
            DIV_DAY:   d = 17'd86400;
            DIV_WEEK:  d = 17'd7;
            DIV_HOUR:  d = 17'd3600;
            DIV_MIN:   d = 17'd60;
            DIV_CYCLE: d = 17'd1461;
            default:   d = 17'd1;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Program: {op, divisor, shift start, jump target}
    function automatic esuc_ctl_t ucode(input logic [PC_W-1:0] pc);
        esuc_ctl_t c;
        case (pc)
            4'd0:    c = '{OP_IDLE,       DIV_DAY,   4'd15, 4'd1};
            4'd1:    c = '{OP_REDUCE,     DIV_DAY,   4'd0,  4'd1};
            4'd2:    c = '{OP_SPLIT_DAY,  DIV_DAY,   4'd12, 4'd0};
            4'd3:    c = '{OP_REDUCE,     DIV_WEEK,  4'd0,  4'd3};
            4'd4:    c = '{OP_PUT_WDAY,   DIV_DAY,   4'd4,  4'd0};
            4'd5:    c = '{OP_REDUCE,     DIV_HOUR,  4'd0,  4'd5};
            4'd6:    c = '{OP_PUT_HOUR,   DIV_DAY,   4'd5,  4'd0};
            4'd7:    c = '{OP_REDUCE,     DIV_MIN,   4'd0,  4'd7};
            4'd8:    c = '{OP_PUT_MIN,    DIV_DAY,   4'd5,  4'd0};
            4'd9:    c = '{OP_REDUCE,     DIV_CYCLE, 4'd0,  4'd9};
            4'd10:   c = '{OP_PUT_CYCLE,  DIV_DAY,   4'd0,  4'd0};
            4'd11:   c = '{OP_YEAR_STEP,  DIV_DAY,   4'd0,  4'd11};
            4'd12:   c = '{OP_PUT_YDAY,   DIV_DAY,   4'd0,  4'd0};
            4'd13:   c = '{OP_MONTH_STEP, DIV_DAY,   4'd0,  4'd13};
            4'd14:   c = '{OP_FINISH,     DIV_DAY,   4'd0,  4'd0};
            default: c = '{OP_IDLE,       DIV_DAY,   4'd15, 4'd1};
        endcase
        return c;
    endfunction

endpackage

>>> rtl/esuc_core.sv
`timescale 1ns / 1ps
// Microcoded sequencer and datapath: shift-subtract reduction, year and month walks.
// Depends on esuc_pkg for the program table, control word and result types.
module esuc_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  esuc_pkg::esuc_cmd_t   cmd,
    input  logic [31:0]           seconds,
    output esuc_pkg::esuc_stat_t  stat,
    output esuc_pkg::esuc_res_t   res
);

    logic [esuc_pkg::PC_W-1:0]  pc_reg,   pc_next;
    logic [esuc_pkg::CNT_W-1:0] cnt_reg,  cnt_next;
    logic [esuc_pkg::ACC_W-1:0] acc_reg,  acc_next;
    logic [esuc_pkg::QUO_W-1:0] quo_reg,  quo_next;
    logic [15:0]                dnum_reg, dnum_next;
    logic [16:0]                secs_reg, secs_next;
    esuc_pkg::esuc_res_t        res_reg,  res_next;

    esuc_pkg::esuc_ctl_t        ctl;
    logic [esuc_pkg::ACC_W-1:0] shifted;
    logic                       ge;
    logic                       leap;
    logic [4:0]                 mlen;

    always_comb
    begin
        ctl     = esuc_pkg::ucode(pc_reg);
        shifted = esuc_pkg::ACC_W'(esuc_pkg::divisor(ctl.csel)) << cnt_reg;
        ge      = acc_reg >= shifted;
        leap    = res_reg.years_since_1900[1:0] == 2'd0;
        mlen    = esuc_pkg::month_len(res_reg.month_index, leap);

        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        dnum_next = dnum_reg;
        secs_next = secs_reg;
        res_next  = res_reg;

        case (ctl.op)
            esuc_pkg::OP_IDLE:
            begin
                if (cmd.start)
                begin
                    acc_next = {seconds[31], seconds} + esuc_pkg::EPOCH_BIAS;
                    quo_next = '0;
                    cnt_next = ctl.cnt;
                    pc_next  = ctl.target;
                end
            end
            esuc_pkg::OP_REDUCE:
            begin
                if (ge)
                begin
                    acc_next = acc_reg - shifted;
                end
                quo_next = {quo_reg[esuc_pkg::QUO_W-2:0], ge};
                cnt_next = cnt_reg - 4'd1;
                pc_next  = (cnt_reg != '0) ? ctl.target : pc_reg + 4'd1;
            end
            esuc_pkg::OP_SPLIT_DAY:
            begin
                dnum_next = quo_reg;
                secs_next = acc_reg[16:0];
                acc_next  = esuc_pkg::ACC_W'(quo_reg) + esuc_pkg::WEEK_BIAS;
                quo_next  = '0;
                cnt_next  = ctl.cnt;
                pc_next   = pc_reg + 4'd1;
            end
            esuc_pkg::OP_PUT_WDAY:
            begin
                res_next.weekday = acc_reg[2:0];
                acc_next = esuc_pkg::ACC_W'(secs_reg);
                quo_next = '0;
                cnt_next = ctl.cnt;
                pc_next  = pc_reg + 4'd1;
            end
            esuc_pkg::OP_PUT_HOUR:
            begin
                res_next.hour_of_day = quo_reg[4:0];
                quo_next = '0;
                cnt_next = ctl.cnt;
                pc_next  = pc_reg + 4'd1;
            end
            esuc_pkg::OP_PUT_MIN:
            begin
                res_next.minute_of_hour   = quo_reg[5:0];
                res_next.second_of_minute = acc_reg[5:0];
                acc_next = esuc_pkg::ACC_W'(dnum_reg);
                quo_next = '0;
                cnt_next = ctl.cnt;
                pc_next  = pc_reg + 4'd1;
            end
            esuc_pkg::OP_PUT_CYCLE:
            begin
                // four-year cycles start at 1901
                res_next.years_since_1900 = {quo_reg[5:0], 2'b01};
                pc_next = pc_reg + 4'd1;
            end
            esuc_pkg::OP_YEAR_STEP:
            begin
                if (acc_reg[10:0] >= esuc_pkg::DAYS_COMMON_YEAR && !leap)
                begin
                    acc_next = acc_reg - esuc_pkg::ACC_W'(esuc_pkg::DAYS_COMMON_YEAR);
                    res_next.years_since_1900 = res_reg.years_since_1900 + 8'd1;
                    pc_next  = ctl.target;
                end
                else
                begin
                    pc_next = pc_reg + 4'd1;
                end
            end
            esuc_pkg::OP_PUT_YDAY:
            begin
                res_next.day_of_year = acc_reg[8:0];
                res_next.month_index = '0;
                pc_next = pc_reg + 4'd1;
            end
            esuc_pkg::OP_MONTH_STEP:
            begin
                if (acc_reg[8:0] >= 9'(mlen) && res_reg.month_index != esuc_pkg::MONTH_DEC)
                begin
                    acc_next = acc_reg - esuc_pkg::ACC_W'(mlen);
                    res_next.month_index = res_reg.month_index + 4'd1;
                    pc_next  = ctl.target;
                end
                else
                begin
                    res_next.day_of_month = acc_reg[4:0] + 5'd1;
                    pc_next = pc_reg + 4'd1;
                end
            end
            esuc_pkg::OP_FINISH:
            begin
                if (cmd.take)
                begin
                    pc_next = ctl.target;
                end
            end
            default:
            begin
                pc_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        dnum_reg <= dnum_next;
        secs_reg <= secs_next;
        res_reg  <= res_next;
    end

    assign stat.idle = ctl.op == esuc_pkg::OP_IDLE;
    assign stat.done = ctl.op == esuc_pkg::OP_FINISH;
    assign res       = res_reg;

endmodule

>>> rtl/epoch_seconds_to_utc_calendar.sv
`timescale 1ns / 1ps
// Top level: stream ports, output register, one esuc_core sequencer.
// Depends on esuc_pkg and esuc_core.
// Timing: the year walk (1 to 4 steps) and the month walk (1 to 12 steps) of the microcode
// program make the time from input acceptance to m_tvalid depend on the input.
// One item at a time: s_tready stays low until the single shift-subtract datapath has passed
// its result to the output register; 16 of its steps go to the division by 86400.
// Reset: rst_n clears the program counter, the step counter and m_tvalid; the block is idle and ready after reset.
module epoch_seconds_to_utc_calendar
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
    // [21:17] day_of_month, [25:22] month_index, [33:26] years_since_1900,
    // [36:34] weekday, [45:37] day_of_year, [47:46] zero
    output logic [47:0] m_tdata
);

    esuc_pkg::esuc_cmd_t  cmd;
    esuc_pkg::esuc_stat_t stat;
    esuc_pkg::esuc_res_t  res;

    logic                                m_tvalid_reg, m_tvalid_next;
    logic [esuc_pkg::TDATA_OUT_W-1:0]    m_tdata_reg,  m_tdata_next;

    assign s_tready  = stat.idle;
    assign cmd.start = s_tvalid && stat.idle;
    assign cmd.take  = !m_tvalid_reg || m_tready;

    esuc_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .seconds (s_tdata),
        .stat    (stat),
        .res     (res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (stat.done && cmd.take)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, res};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> tb/epoch_seconds_to_utc_calendar_tb.sv
`timescale 1ns / 1ps
// Testbench for epoch_seconds_to_utc_calendar: streams signed epoch counts through the block
// and compares every calendar breakdown against a scoreboard with its own calendar predictor.
// Depends on esuc_pkg and the epoch_seconds_to_utc_calendar RTL.
module epoch_seconds_to_utc_calendar_tb;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int RANDOM_ITEMS  = 400;
    localparam int LONG_HOLD     = 600;
    localparam int DAY_SECONDS   = 86400;

    function automatic int is_leap(input longint yoff);
        longint y;
        y = yoff + 1900;
        if (y % 100 == 0)
        begin
            return (y % 400 == 0) ? 1 : 0;
        end
        return (y % 4 == 0) ? 1 : 0;
    endfunction

    function automatic longint month_length(input longint mon, input longint yoff);
        case (mon)
            1:       return (is_leap(yoff) != 0) ? 29 : 28;
            3, 5, 8, 10: return 30;
            default: return 31;
        endcase
    endfunction

    class calendar_scoreboard;
        esuc_pkg::esuc_res_t expected_q[$];
        int                  mismatches;

        function new();
            mismatches = 0;
        endfunction

        function esuc_pkg::esuc_res_t utc_breakdown(input logic signed [31:0] secs);
            longint              t;
            longint              day_num;
            longint              sod;
            longint              wd;
            longint              yday;
            longint              yr;
            longint              mon;
            esuc_pkg::esuc_res_t r;
            t = secs;
            day_num = t / DAY_SECONDS;
            sod = t % DAY_SECONDS;
            if (sod < 0)
            begin
                sod += DAY_SECONDS;
                day_num -= 1;
            end
            wd = (day_num + 4) % 7;
            if (wd < 0)
            begin
                wd += 7;
            end
            yr = 70;
            yday = day_num;
            while (yday >= 365 + is_leap(yr))
            begin
                yday -= 365 + is_leap(yr);
                yr++;
            end
            while (yday < 0)
            begin
                yr--;
                yday += 365 + is_leap(yr);
            end
            r.day_of_year = yday[8:0];
            mon = 0;
            while (yday >= month_length(mon, yr) && mon < 11)
            begin
                yday -= month_length(mon, yr);
                mon++;
            end
            r.second_of_minute = 6'(sod % 60);
            r.minute_of_hour   = 6'((sod % 3600) / 60);
            r.hour_of_day      = 5'(sod / 3600);
            r.day_of_month     = 5'(yday + 1);
            r.month_index      = 4'(mon);
            r.years_since_1900 = 8'(yr);
            r.weekday          = 3'(wd);
            return r;
        endfunction

        function void note_input(input logic [31:0] secs);
            expected_q.push_back(utc_breakdown(secs));
        endfunction

        task report_mismatch(input string what, input longint got_v, input longint want_v);
            mismatches++;
            if (mismatches <= 40)
            begin
                $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got_v, want_v,
                         $realtime);
            end
        endtask

        task check_result(input logic [47:0] data);
            esuc_pkg::esuc_res_t got;
            esuc_pkg::esuc_res_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with no pending item", data, 0);
                return;
            end
            want = expected_q.pop_front();
            got = data[45:0];
            if (data[47:46] !== 2'b00)
                report_mismatch("padding bits", data[47:46], 0);
            if (got.second_of_minute !== want.second_of_minute)
                report_mismatch("second_of_minute", got.second_of_minute, want.second_of_minute);
            if (got.minute_of_hour !== want.minute_of_hour)
                report_mismatch("minute_of_hour", got.minute_of_hour, want.minute_of_hour);
            if (got.hour_of_day !== want.hour_of_day)
                report_mismatch("hour_of_day", got.hour_of_day, want.hour_of_day);
            if (got.day_of_month !== want.day_of_month)
                report_mismatch("day_of_month", got.day_of_month, want.day_of_month);
            if (got.month_index !== want.month_index)
                report_mismatch("month_index", got.month_index, want.month_index);
            if (got.years_since_1900 !== want.years_since_1900)
                report_mismatch("years_since_1900", got.years_since_1900,
                                want.years_since_1900);
            if (got.weekday !== want.weekday)
                report_mismatch("weekday", got.weekday, want.weekday);
            if (got.day_of_year !== want.day_of_year)
                report_mismatch("day_of_year", got.day_of_year, want.day_of_year);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    calendar_scoreboard sb;
    int                 results_taken = 0;
    int                 cycle_count = 0;

    epoch_seconds_to_utc_calendar DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata);
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata);
                results_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : ready_driver
        int stall;
        int free_run;
        bit long_hold_done;
        free_run = 0;
        long_hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && results_taken >= 40)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (free_run > 0)
            begin
                m_tready <= 1'b1;
                free_run--;
            end
            else
            begin
                stall = idle_cycles();
                if (stall == 0)
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 19) == 0)
                        free_run = $urandom_range(50, 200);
                end
                else
                begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(posedge clk);
                end
            end
        end
    end

    task send_epoch(input logic [31:0] secs, input bit gapless);
        int gap;
        gap = gapless ? 0 : idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_epoch();
        int     kind;
        longint v;
        kind = $urandom_range(0, 9);
        if (kind < 5)
            return $urandom;
        if (kind < 8)
        begin
            v = longint'($urandom_range(0, 49709)) - 24855;
            v = v * DAY_SECONDS - longint'($urandom_range(0, 1));
            return v[31:0];
        end
        v = longint'($urandom_range(0, 252460800)) - 126230400;
        return v[31:0];
    endfunction

    initial
    begin : stimulus
        logic [31:0] directed_q[$];
        bit          gapless;
        directed_q = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                       32'd59, 32'd3599, 32'd86399, 32'd86400,
                       -32'sd86400, -32'sd86401,
                       32'd68169600, 32'd68256000, 32'd951782400, 32'd951868800,
                       32'd946684799, 32'd978220800, 32'd978307200,
                       -32'sd58060800, -32'sd63158401,
                       32'h55555555, 32'hAAAAAAAA};
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_q[i])
            send_epoch(directed_q[i], 1'b0);
        gapless = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 25 == 0)
                gapless = ($urandom_range(0, 3) == 0);
            send_epoch(random_epoch(), gapless);
        end
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
